// ===== hw/rtl/per_stream_jitter_buffer_macros.svh =====
// ---------------------------------------------------------------------------
// Jitter buffer assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PER_STREAM_JITTER_BUFFER_MACROS_SVH
`define PER_STREAM_JITTER_BUFFER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define PSJB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PSJB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/psjb_pkg.sv =====
// ---------------------------------------------------------------------------
// Jitter buffer package
// Sizes, status codes, state and memory entry types for the slot manager.
// ---------------------------------------------------------------------------
package psjb_pkg;

  localparam int STREAMS   = 16;
  localparam int SLOTS     = 8;
  localparam int STREAM_W  = 4;
  localparam int STREAM_AW = $clog2(STREAMS);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int FILL_W    = $clog2(SLOTS + 1);
  localparam int SEQ_W     = 32;
  localparam int GAP_W     = 8;
  localparam int STATUS_W  = 4;

  localparam logic [GAP_W-1:0] GAP_RESET = 8'd10;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_PLAY   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_FULL      = 4'd2,
    ST_LATE      = 4'd3,
    ST_RESYNC    = 4'd4,
    ST_PLAYED    = 4'd5,
    ST_UNDERRUN  = 4'd6,
    ST_BUFFERING = 4'd7,
    ST_BUF_DONE  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MIN2,
    S_FIN
  } state_t;

  // Per-stream control word held in the control memory.
  typedef struct packed {
    logic [SEQ_W-1:0]  last_played;
    logic              buffering;
    logic [FILL_W-1:0] fill;
    logic [SLOTS-1:0]  valid;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    last_played: '0,
    buffering:   1'b1,
    fill:        '0,
    valid:       '0
  };

  // Candidate in the oldest-frame search.
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    logic [SEQ_W-1:0]  seq;
  } cand_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
  } result_t;

  // Keeps the left candidate on equal sequence numbers, so the lower slot wins.
  function automatic cand_t pick_older(cand_t a, cand_t b);
    cand_t r;
    if (a.vld && (!b.vld || (a.seq <= b.seq))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/per_stream_jitter_buffer.sv =====
// ---------------------------------------------------------------------------
// Per-stream jitter buffer slot manager
// Tracks frame slots for each voice stream, places arriving frames and picks
// the oldest frame on each play tick.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                                    | Direction
//  ---------+------------------------------------------+----------
//  input    | in_valid/in_ready, in_op, in_stream,     | in
//           | in_seq                                   |
//  result   | out_valid/out_ready, out_status,         | out
//           | out_slot, out_seq_out                    |
//  config   | cfg_we, cfg_wdata (resync gap)           | in
//
// An arrival or a tick during buffering reads the stream's control word and slot
// row on the transfer, then evaluates and writes back in the evaluation state.
// A play tick that searches for the oldest slot goes through the read, two
// registered levels of the minimum tree, and the last level with the write-back.
// A result waiting in the output register holds the write-back and the input.
// Per-stream written flags make unwritten control words read as reset values.
//
module per_stream_jitter_buffer (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [psjb_pkg::STREAM_W-1:0]  in_stream,
  input  logic [psjb_pkg::SEQ_W-1:0]     in_seq,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [psjb_pkg::STATUS_W-1:0]  out_status,
  output logic [psjb_pkg::SLOT_W-1:0]    out_slot,
  output logic [psjb_pkg::SEQ_W-1:0]     out_seq_out,

  input  logic                           cfg_we,
  input  logic [psjb_pkg::GAP_W-1:0]     cfg_wdata
);

`include "per_stream_jitter_buffer_macros.svh"

  // Control state and configuration.
  psjb_pkg::state_t                   state_r, state_nxt;
  logic [psjb_pkg::GAP_W-1:0]         gap_r;
  logic [psjb_pkg::STREAMS-1:0]       written_r;
  logic                               out_valid_r;

  // Latched item.
  logic                               op_r;
  logic [psjb_pkg::STREAM_AW-1:0]     stream_r;
  logic [psjb_pkg::SEQ_W-1:0]         seq_r;

  // Memories and their registered read data.
  psjb_pkg::ctrl_t                    ctrl_mem [psjb_pkg::STREAMS];
  logic [psjb_pkg::SLOTS-1:0][psjb_pkg::SEQ_W-1:0] slot_mem [psjb_pkg::STREAMS];
  psjb_pkg::ctrl_t                    ctrl_rd_r;
  logic [psjb_pkg::SLOTS-1:0][psjb_pkg::SEQ_W-1:0] slot_rd_r;
  logic                               written_rd_r;
  psjb_pkg::ctrl_t                    ctrl_q;

  // Oldest-frame search tree.
  psjb_pkg::cand_t                    l1_r [psjb_pkg::SLOTS/2];
  psjb_pkg::cand_t                    l1_nxt [psjb_pkg::SLOTS/2];
  psjb_pkg::cand_t                    l2_r [psjb_pkg::SLOTS/4];
  psjb_pkg::cand_t                    l2_nxt [psjb_pkg::SLOTS/4];
  psjb_pkg::cand_t                    oldest;

  // Write-back and result.
  logic                               in_xfer;
  logic                               out_free;
  logic                               commit;
  logic                               slot_we;
  psjb_pkg::ctrl_t                    ctrl_wr;
  psjb_pkg::result_t                  res;
  psjb_pkg::result_t                  out_res_r;

  // Arrival evaluation.
  logic [psjb_pkg::SLOTS-1:0]         dup_hit;
  logic [psjb_pkg::SLOT_W-1:0]        free_idx;
  logic                               any_free;
  logic [psjb_pkg::SEQ_W-1:0]         lag;

  assign in_ready = (state_r == psjb_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // A stream never written back still holds its reset control word.
  assign ctrl_q = written_rd_r ? ctrl_rd_r : psjb_pkg::CTRL_RESET;

  // Memory reads happen on the input transfer; writes on commit.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ctrl_rd_r <= ctrl_mem[in_stream[psjb_pkg::STREAM_AW-1:0]];
      slot_rd_r <= slot_mem[in_stream[psjb_pkg::STREAM_AW-1:0]];
    end
    if (commit) begin
      ctrl_mem[stream_r] <= ctrl_wr;
    end
    if (commit && slot_we) begin
      slot_mem[stream_r][free_idx] <= seq_r;
    end
  end

  // Item latch, search tree and output payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r         <= in_op;
      stream_r     <= in_stream[psjb_pkg::STREAM_AW-1:0];
      seq_r        <= in_seq;
      written_rd_r <= written_r[in_stream[psjb_pkg::STREAM_AW-1:0]];
    end
    l1_r <= l1_nxt;
    l2_r <= l2_nxt;
    if (commit) begin
      out_res_r <= res;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psjb_pkg::S_IDLE;
      gap_r       <= psjb_pkg::GAP_RESET;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      if (commit) begin
        written_r[stream_r] <= 1'b1;
        out_valid_r         <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot compares on the row that was read: duplicates and the first free slot.
  always_comb begin
    any_free = !(&ctrl_q.valid);
    free_idx = '0;
    for (int i = psjb_pkg::SLOTS - 1; i >= 0; i--) begin
      dup_hit[i] = ctrl_q.valid[i] && (slot_rd_r[i] == seq_r);
      if (!ctrl_q.valid[i]) begin
        free_idx = psjb_pkg::SLOT_W'(i);
      end
    end
    lag = ctrl_q.last_played - seq_r;
  end

  // Three-level minimum tree; the first two levels are registered.
  always_comb begin
    psjb_pkg::cand_t ca;
    psjb_pkg::cand_t cb;
    for (int p = 0; p < psjb_pkg::SLOTS / 2; p++) begin
      ca.vld = ctrl_q.valid[2*p];
      ca.idx = psjb_pkg::SLOT_W'(2*p);
      ca.seq = slot_rd_r[2*p];
      cb.vld = ctrl_q.valid[2*p+1];
      cb.idx = psjb_pkg::SLOT_W'(2*p+1);
      cb.seq = slot_rd_r[2*p+1];
      l1_nxt[p] = psjb_pkg::pick_older(ca, cb);
    end
    for (int q = 0; q < psjb_pkg::SLOTS / 4; q++) begin
      l2_nxt[q] = psjb_pkg::pick_older(l1_r[2*q], l1_r[2*q+1]);
    end
    oldest = psjb_pkg::pick_older(l2_r[0], l2_r[1]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psjb_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = psjb_pkg::S_EVAL;
        end
      end
      psjb_pkg::S_EVAL: begin
        if (op_r == psjb_pkg::OP_PLAY && !ctrl_q.buffering) begin
          state_nxt = psjb_pkg::S_MIN2;
        end else if (out_free) begin
          state_nxt = psjb_pkg::S_IDLE;
        end
      end
      psjb_pkg::S_MIN2: begin
        state_nxt = psjb_pkg::S_FIN;
      end
      psjb_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = psjb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = psjb_pkg::S_IDLE;
      end
    endcase
  end

  // Write-back word and result. Commit waits for the output register.
  always_comb begin
    commit     = 1'b0;
    slot_we    = 1'b0;
    ctrl_wr    = ctrl_q;
    res.status = psjb_pkg::ST_LATE;
    res.slot   = '0;
    res.seq    = seq_r;
    case (state_r)
      psjb_pkg::S_EVAL: begin
        if (op_r == psjb_pkg::OP_ARRIVE) begin
          commit = out_free;
          if (seq_r > ctrl_q.last_played) begin
            if (|dup_hit) begin
              res.status = psjb_pkg::ST_DUPLICATE;
            end else if (any_free) begin
              res.status = psjb_pkg::ST_STORED;
              res.slot   = free_idx;
              slot_we    = 1'b1;
              ctrl_wr.valid[free_idx] = 1'b1;
              ctrl_wr.fill = ctrl_q.fill + psjb_pkg::FILL_W'(1);
            end else begin
              res.status = psjb_pkg::ST_FULL;
            end
          end else if (lag > psjb_pkg::SEQ_W'(gap_r)) begin
            // Too far behind: restart the stream at this frame.
            res.status          = psjb_pkg::ST_RESYNC;
            ctrl_wr.last_played = seq_r;
            ctrl_wr.valid       = '0;
            ctrl_wr.fill        = '0;
          end
        end else if (ctrl_q.buffering) begin
          commit  = out_free;
          res.seq = '0;
          if (ctrl_q.fill >= psjb_pkg::FILL_W'(psjb_pkg::SLOTS - 1)) begin
            res.status        = psjb_pkg::ST_BUF_DONE;
            ctrl_wr.buffering = 1'b0;
          end else begin
            res.status = psjb_pkg::ST_BUFFERING;
          end
        end
      end
      psjb_pkg::S_FIN: begin
        commit = out_free;
        if (!oldest.vld) begin
          res.status        = psjb_pkg::ST_UNDERRUN;
          res.seq           = '0;
          ctrl_wr.buffering = 1'b1;
        end else begin
          res.status          = psjb_pkg::ST_PLAYED;
          res.slot            = oldest.idx;
          res.seq             = oldest.seq;
          ctrl_wr.valid[oldest.idx] = 1'b0;
          ctrl_wr.last_played = oldest.seq;
          if (ctrl_q.fill != '0) begin
            ctrl_wr.fill = ctrl_q.fill - psjb_pkg::FILL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_res_r.status;
  assign out_slot    = out_res_r.slot;
  assign out_seq_out = out_res_r.seq;

  // Checks on the sequencing and on the written-back state.
  `PSJB_ASSERT(a_xfer_to_eval, in_xfer |=> (state_r == psjb_pkg::S_EVAL), "transfer did not start evaluation")
  `PSJB_NEVER(a_no_overwrite, commit && out_valid_r && !out_ready, "result overwrote a pending result")
  `PSJB_ASSERT(a_fill_matches, commit |-> ($countones(ctrl_wr.valid) == int'(ctrl_wr.fill)), "fill count disagrees with slot flags")
  `PSJB_ASSERT(a_fin_after_min, (state_r == psjb_pkg::S_FIN) |-> ($past(state_r) == psjb_pkg::S_MIN2 || $past(state_r) == psjb_pkg::S_FIN), "search finished without its middle level")

endmodule

// ===== bench/per_stream_jitter_buffer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Jitter buffer slot manager testbench
// Sends frame arrivals and play ticks over the valid/ready input channel. An
// in-bench copy of the slot bookkeeping predicts one status report for each
// transfer, and each report from the result channel is compared against it.
// ---------------------------------------------------------------------------
module per_stream_jitter_buffer_tb;

  // One request as it travels on the input channel.
  typedef struct packed {
    logic                          op;
    logic [psjb_pkg::STREAM_W-1:0] stream;
    logic [psjb_pkg::SEQ_W-1:0]    seq;
  } jb_req_t;

  // The receiver switches between these ready behaviors every so often.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SELDOM,
    RX_PATTERN
  } rx_mode_t;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 105;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic [psjb_pkg::STREAM_W-1:0] LAST_STREAM =
    psjb_pkg::STREAM_W'(psjb_pkg::STREAMS - 1);

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          in_op     = 1'b0;
  logic [psjb_pkg::STREAM_W-1:0] in_stream = '0;
  logic [psjb_pkg::SEQ_W-1:0]    in_seq    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [psjb_pkg::STATUS_W-1:0] out_status;
  logic [psjb_pkg::SLOT_W-1:0]   out_slot;
  logic [psjb_pkg::SEQ_W-1:0]    out_seq_out;
  logic                          cfg_we    = 1'b0;
  logic [psjb_pkg::GAP_W-1:0]    cfg_wdata = '0;

  // Requests not yet offered, and the reports still owed by the block.
  jb_req_t           req_backlog[$];
  psjb_pkg::result_t report_backlog[$];

  // Shadow copy of the per-stream bookkeeping and of the resync gap register.
  logic [psjb_pkg::SEQ_W-1:0] lp_seq[psjb_pkg::STREAMS];
  bit                         fill_wait[psjb_pkg::STREAMS];
  int unsigned                held_cnt[psjb_pkg::STREAMS];
  logic [psjb_pkg::SEQ_W-1:0] row_seq[psjb_pkg::STREAMS][psjb_pkg::SLOTS];
  bit                         row_busy[psjb_pkg::STREAMS][psjb_pkg::SLOTS];
  logic [psjb_pkg::GAP_W-1:0] gap_cfg;

  jb_req_t  offered;
  int       mismatches  = 0;
  int       cycle_count = 0;
  bit       hold_req    = 1'b0;

  per_stream_jitter_buffer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_stream  (in_stream),
    .in_seq     (in_seq),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_seq_out(out_seq_out),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow bookkeeping and returns the report that
  // the block must produce for it.
  function automatic psjb_pkg::result_t jitter_step(input jb_req_t req);
    psjb_pkg::result_t rep;
    int                s;
    int                best;
    bit                dup;
    rep = '0;
    s = int'(req.stream) % psjb_pkg::STREAMS;
    best = -1;
    dup = 1'b0;
    if (req.op == psjb_pkg::OP_ARRIVE) begin
      rep.seq = req.seq;
      if (req.seq > lp_seq[s]) begin
        for (int i = 0; i < psjb_pkg::SLOTS; i++) begin
          if (row_busy[s][i] && row_seq[s][i] == req.seq) begin
            dup = 1'b1;
          end
        end
        // Walk down so that the lowest free slot is the one left in best.
        for (int i = psjb_pkg::SLOTS - 1; i >= 0; i--) begin
          if (!row_busy[s][i]) begin
            best = i;
          end
        end
        if (dup) begin
          rep.status = psjb_pkg::ST_DUPLICATE;
        end else if (best < 0) begin
          rep.status = psjb_pkg::ST_FULL;
        end else begin
          row_busy[s][best] = 1'b1;
          row_seq[s][best] = req.seq;
          held_cnt[s]++;
          rep.status = psjb_pkg::ST_STORED;
          rep.slot = best[psjb_pkg::SLOT_W-1:0];
        end
      end else if (lp_seq[s] - req.seq > gap_cfg) begin
        // Far too late: the stream restarts from this frame with no slots held.
        lp_seq[s] = req.seq;
        for (int i = 0; i < psjb_pkg::SLOTS; i++) begin
          row_busy[s][i] = 1'b0;
        end
        held_cnt[s] = 0;
        rep.status = psjb_pkg::ST_RESYNC;
      end else begin
        rep.status = psjb_pkg::ST_LATE;
      end
    end else if (fill_wait[s]) begin
      if (held_cnt[s] >= psjb_pkg::SLOTS - 1) begin
        fill_wait[s] = 1'b0;
        rep.status = psjb_pkg::ST_BUF_DONE;
      end else begin
        rep.status = psjb_pkg::ST_BUFFERING;
      end
    end else begin
      // Strict less-than keeps the lower slot when sequence numbers tie.
      for (int i = 0; i < psjb_pkg::SLOTS; i++) begin
        if (row_busy[s][i] && (best < 0 || row_seq[s][i] < row_seq[s][best])) begin
          best = i;
        end
      end
      if (best < 0) begin
        fill_wait[s] = 1'b1;
        rep.status = psjb_pkg::ST_UNDERRUN;
      end else begin
        row_busy[s][best] = 1'b0;
        lp_seq[s] = row_seq[s][best];
        if (held_cnt[s] > 0) begin
          held_cnt[s]--;
        end
        rep.status = psjb_pkg::ST_PLAYED;
        rep.slot = best[psjb_pkg::SLOT_W-1:0];
        rep.seq = row_seq[s][best];
      end
    end
    return rep;
  endfunction

  function automatic void queue_frame(input logic op,
                                      input logic [psjb_pkg::STREAM_W-1:0] stream,
                                      input logic [psjb_pkg::SEQ_W-1:0] seq);
    jb_req_t req;
    req.op = op;
    req.stream = stream;
    req.seq = seq;
    req_backlog.push_back(req);
  endfunction

  // Register writes happen only with nothing in flight, so the shadow copy of
  // the gap can simply follow the write.
  task automatic set_resync_gap(input logic [psjb_pkg::GAP_W-1:0] gap);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    gap_cfg = gap;
  endtask

  // Returns once every request has been transferred and every report checked.
  task automatic wait_drained;
    @(posedge clk);
    while (req_backlog.size() != 0 || in_valid || report_backlog.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender: bursts of random length separated by random gaps. The payload only
  // changes once the current transfer has happened, and the prediction is made
  // at the transfer edge so that it follows the order the block sees.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        report_backlog.push_back(jitter_step(offered));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          offered = req_backlog.pop_front();
          in_op <= offered.op;
          in_stream <= offered.stream;
          in_seq <= offered.seq;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // Half of the bursts run back to back with the next one.
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a ready pattern that switches among four modes at random, plus one
  // long hold-off on request that lets the block fill up and stall its input.
  rx_mode_t    rx_mode   = RX_ALWAYS;
  int unsigned rx_tick   = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_tick = 0;
      hold_left = 0;
    end else begin
      rx_tick++;
      if (rx_tick % 50 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
          RX_SELDOM: out_ready <= ($urandom_range(0, 9) < 3);
          default:   out_ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  // Monitor: each result transfer is matched against the oldest owed report.
  always @(posedge clk) begin : monitor
    psjb_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_backlog.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: status %0d slot %0d seq %h",
                   out_status, out_slot, out_seq_out);
        end
      end else begin
        want = report_backlog.pop_front();
        if (out_status !== want.status || out_slot !== want.slot ||
            out_seq_out !== want.seq) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected status %0d slot %0d seq %h,",
                     want.status, want.slot, want.seq,
                     " got status %0d slot %0d seq %h",
                     out_status, out_slot, out_seq_out);
          end
        end
      end
    end
  end

  // Watchdog for a block that hangs or loses transfers.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [psjb_pkg::SEQ_W-1:0]    gen_next[psjb_pkg::STREAMS];
    logic [psjb_pkg::STREAM_W-1:0] hot[4];
    logic [psjb_pkg::STREAM_W-1:0] s;
    logic [psjb_pkg::GAP_W-1:0]    gap_plan[PHASES];
    int unsigned                   play_pct;
    int unsigned                   pick;

    gap_cfg = psjb_pkg::GAP_RESET;
    for (int i = 0; i < psjb_pkg::STREAMS; i++) begin
      lp_seq[i] = '0;
      fill_wait[i] = 1'b1;
      held_cnt[i] = 0;
      for (int j = 0; j < psjb_pkg::SLOTS; j++) begin
        row_seq[i][j] = '0;
        row_busy[i][j] = 1'b0;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the gap still at its reset value. Stream 0: a tick
    // while buffering, a frame that is not newer than the last played one, the
    // fill-up that ends buffering, a duplicate and an arrival into a full row.
    queue_frame(psjb_pkg::OP_PLAY, '0, 32'd0);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd0);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd5);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd3);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd7);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd1);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd2);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd4);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd6);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd3);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd100);
    queue_frame(psjb_pkg::OP_ARRIVE, '0, 32'd50);
    queue_frame(psjb_pkg::OP_PLAY, '0, 32'd0);
    queue_frame(psjb_pkg::OP_PLAY, '0, 32'd0);
    // Stream 15: sequence numbers at the top of the range, then a frame at
    // zero that lags far enough to resync, and a tick on the emptied row.
    for (int i = 6; i >= 0; i--) begin
      queue_frame(psjb_pkg::OP_ARRIVE, LAST_STREAM, 32'hFFFF_FFFF - i);
    end
    queue_frame(psjb_pkg::OP_PLAY, LAST_STREAM, 32'hFFFF_FFFF);
    queue_frame(psjb_pkg::OP_PLAY, LAST_STREAM, 32'hFFFF_FFFF);
    queue_frame(psjb_pkg::OP_ARRIVE, LAST_STREAM, 32'd0);
    queue_frame(psjb_pkg::OP_PLAY, LAST_STREAM, 32'd0);
    wait_drained();

    // Each random phase starts with the block idle, so the gap can change.
    gap_plan[0] = 8'd0;
    gap_plan[1] = 8'd255;
    gap_plan[2] = psjb_pkg::GAP_W'($urandom_range(1, 254));
    gap_plan[3] = psjb_pkg::GAP_RESET;
    gap_plan[4] = psjb_pkg::GAP_W'($urandom_range(0, 255));

    for (int i = 0; i < psjb_pkg::STREAMS; i++) begin
      case ($urandom_range(0, 3))
        0:       gen_next[i] = 32'hFFFF_FF00 + $urandom_range(0, 128);
        1:       gen_next[i] = $urandom;
        default: gen_next[i] = $urandom_range(20, 1000);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      set_resync_gap(gap_plan[p]);
      play_pct = $urandom_range(20, 45);
      for (int h = 0; h < 4; h++) begin
        hot[h] = psjb_pkg::STREAM_W'($urandom_range(0, psjb_pkg::STREAMS - 1));
      end
      // Most traffic goes to a few streams so that their rows fill, drain and
      // cycle through buffering; frames arrive mostly in order with jitter.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = ($urandom_range(0, 3) != 0) ?
            hot[2'($urandom_range(0, 3))] :
            psjb_pkg::STREAM_W'($urandom_range(0, psjb_pkg::STREAMS - 1));
        pick = $urandom_range(0, 99);
        if (pick < play_pct) begin
          queue_frame(psjb_pkg::OP_PLAY, s, $urandom);
        end else if (pick < play_pct + 35) begin
          queue_frame(psjb_pkg::OP_ARRIVE, s, gen_next[s] + $urandom_range(0, 3));
          gen_next[s] = gen_next[s] + $urandom_range(1, 2);
        end else if (pick < play_pct + 45) begin
          queue_frame(psjb_pkg::OP_ARRIVE, s, gen_next[s] - $urandom_range(1, 40));
        end else if (pick < play_pct + 49) begin
          queue_frame(psjb_pkg::OP_ARRIVE, s, gen_next[s] - $urandom_range(200, 100000));
        end else if (pick < play_pct + 52) begin
          // The stream jumps to a new place in the sequence space.
          gen_next[s] = $urandom;
          queue_frame(psjb_pkg::OP_ARRIVE, s, gen_next[s]);
        end else begin
          queue_frame(1'($urandom_range(0, 1)),
                      psjb_pkg::STREAM_W'($urandom_range(0, psjb_pkg::STREAMS - 1)),
                      $urandom);
        end
      end
      // In one phase the receiver holds off while the sender keeps offering.
      if (p == 2) begin
        hold_req = 1'b1;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/psjb_pkg.sv
hw/rtl/per_stream_jitter_buffer.sv
bench/per_stream_jitter_buffer_tb.sv
